// ===== hw/rtl/dbb_pkg.sv =====
// dbb_pkg: shared types, widths and saturation helpers for the dab stroke
// bounding box unit. Used by dbb_axis_span and dab_stroke_bounding_box_unit.
// No dependencies.
package dbb_pkg;

  // running position width (16 to 48)
  localparam int COORD_BITS = 32;

  // width of the sum of a position and a 32-bit offset
  localparam int SUM_BITS = ((COORD_BITS > 32) ? COORD_BITS : 32) + 1;

  // width for the per-axis edge arithmetic (pos*128 - size, with margin)
  localparam int EXT_BITS = (COORD_BITS + 10 > 34) ? COORD_BITS + 10 : 34;

  localparam logic signed [SUM_BITS-1:0] POS_MAX =
    SUM_BITS'({(COORD_BITS-1){1'b1}});
  localparam logic signed [SUM_BITS-1:0] POS_MIN = ~POS_MAX;

  localparam logic signed [EXT_BITS-1:0] BOX_MAX = EXT_BITS'(32'h7fff_ffff);
  localparam logic signed [EXT_BITS-1:0] BOX_MIN = ~BOX_MAX;

  typedef enum logic [1:0] {
    MODE_START_SUB = 2'd0,
    MODE_START_PIX = 2'd1,
    MODE_DAB       = 2'd2
  } mode_t;

  // per-axis control from the box stage
  typedef struct packed {
    logic pixel;  // pixel mode arithmetic
    logic seed;   // start item: single pixel at the origin
  } axis_ctl_t;

  function automatic logic signed [COORD_BITS-1:0] sat_pos(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] c;
    c = v;
    if (v > POS_MAX) begin
      c = POS_MAX;
    end else if (v < POS_MIN) begin
      c = POS_MIN;
    end
    return c[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] sat_box(
    input logic signed [EXT_BITS-1:0] v
  );
    logic signed [EXT_BITS-1:0] c;
    c = v;
    if (v > BOX_MAX) begin
      c = BOX_MAX;
    end else if (v < BOX_MIN) begin
      c = BOX_MIN;
    end
    return c[31:0];
  endfunction

endpackage

// ===== hw/rtl/dbb_axis_span.sv =====
// dbb_axis_span: low and high pixel edge of one dab or start pixel on one axis.
// Depends on dbb_pkg.
module dbb_axis_span
  import dbb_pkg::*;
(
  input  logic signed [COORD_BITS-1:0] pos,
  input  logic        [15:0]           dsize,
  input  axis_ctl_t                    ctl,
  output logic signed [31:0]           lo,
  output logic signed [31:0]           hi
);

  logic signed [EXT_BITS-1:0] pos_e;
  logic signed [EXT_BITS-1:0] size_e;
  logic signed [EXT_BITS-1:0] span_e;
  logic signed [EXT_BITS-1:0] half_e;
  logic signed [EXT_BITS-1:0] scaled;
  logic signed [EXT_BITS-1:0] scaled_sh;
  logic signed [EXT_BITS-1:0] scaled_fix;
  logic signed [EXT_BITS-1:0] sub_lo;
  logic signed [EXT_BITS-1:0] sub_hi;
  logic signed [EXT_BITS-1:0] pix_lo;
  logic signed [EXT_BITS-1:0] pix_hi;
  logic signed [EXT_BITS-1:0] quarter_sh;
  logic signed [EXT_BITS-1:0] quarter_fix;
  logic signed [EXT_BITS-1:0] quarter;
  logic signed [EXT_BITS-1:0] lo_e;
  logic signed [EXT_BITS-1:0] hi_e;
  logic        [16:0]         diam;

  assign pos_e  = {{(EXT_BITS-COORD_BITS){pos[COORD_BITS-1]}}, pos};
  assign size_e = {{(EXT_BITS-16){1'b0}}, dsize};
  assign span_e = {{(EXT_BITS-8){1'b0}}, dsize[15:8]};
  assign diam   = {1'b0, dsize} + 17'd1;
  assign half_e = {{(EXT_BITS-16){1'b0}}, diam[16:1]};

  // subpixel: trunc((128*pos - size) / 512) toward zero
  assign scaled     = (pos_e <<< 7) - size_e;
  assign scaled_sh  = scaled >>> 9;
  assign scaled_fix = {{(EXT_BITS-1){1'b0}},
                       scaled[EXT_BITS-1] && (scaled[8:0] != 9'd0)};
  assign sub_lo     = scaled_sh + scaled_fix;
  assign sub_hi     = sub_lo + span_e;

  assign pix_lo = pos_e - half_e;
  assign pix_hi = pix_lo + size_e;

  // start pixel in subpixel mode is trunc(pos / 4)
  assign quarter_sh  = pos_e >>> 2;
  assign quarter_fix = {{(EXT_BITS-1){1'b0}},
                        pos[COORD_BITS-1] && (pos[1:0] != 2'd0)};
  assign quarter     = quarter_sh + quarter_fix;

  always_comb begin
    if (ctl.seed) begin
      lo_e = ctl.pixel ? pos_e : quarter;
      hi_e = lo_e;
    end else if (ctl.pixel) begin
      lo_e = pix_lo;
      hi_e = pix_hi;
    end else begin
      lo_e = sub_lo;
      hi_e = sub_hi;
    end
  end

  assign lo = sat_box(lo_e);
  assign hi = sat_box(hi_e);

endmodule

// ===== hw/rtl/dab_stroke_bounding_box_unit.sv =====
// dab_stroke_bounding_box_unit: top level, running position, box merge and
// result register. Depends on dbb_pkg and dbb_axis_span.
//
//   channel  dir  tdata (low bit up)                      tuser / tlast
//   s_*      in   coord_x, coord_y, dsize (80 bits)       tuser mode, tlast last
//   m_*      out  box_left, box_top, box_right, box_bottom (128 bits)  none
//
// one request per cycle while s_tready is high; a request's box passes the
// input register, position update and box merge before it leaves the result register.
// rst is synchronous: position, box and mode state go to zero, subpixel.
// requests without last keep flowing while a result waits; the pipeline
// only holds when a last request meets a result register that is not taken.
module dab_stroke_bounding_box_unit
  import dbb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // coord_x[31:0], coord_y[63:32], dsize[79:64]
  input  logic [1:0]   s_tuser,   // mode
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // box_left, box_top, box_right, box_bottom
);

  logic advance;

  // input register
  logic               v1;
  logic [1:0]         mode1;
  logic signed [31:0] cx1;
  logic signed [31:0] cy1;
  logic [15:0]        size1;
  logic               last1;

  // position state
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_x_next;
  logic signed [COORD_BITS-1:0] pos_y_next;
  logic                         pixel_mode;
  logic                         pixel_mode_next;
  logic signed [SUM_BITS-1:0]   sum_x;
  logic signed [SUM_BITS-1:0]   sum_y;
  logic signed [SUM_BITS-1:0]   org_x;
  logic signed [SUM_BITS-1:0]   org_y;

  // box stage register
  logic                         v2;
  logic [1:0]                   mode2;
  logic                         pix2;
  logic signed [COORD_BITS-1:0] px2;
  logic signed [COORD_BITS-1:0] py2;
  logic [15:0]                  size2;
  logic                         last2;

  // box state
  logic signed [31:0] min_x, min_y, max_x, max_y;
  logic signed [31:0] min_x_next, min_y_next, max_x_next, max_y_next;
  logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
  axis_ctl_t          ctl;

  assign advance  = !(v2 && last2 && m_tvalid && !m_tready);
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_tvalid) begin
      cx1   <= s_tdata[31:0];
      cy1   <= s_tdata[63:32];
      size1 <= s_tdata[79:64];
      mode1 <= s_tuser;
      last1 <= s_tlast;
    end
  end

  assign sum_x = {{(SUM_BITS-COORD_BITS){pos_x[COORD_BITS-1]}}, pos_x}
               + {{(SUM_BITS-32){cx1[31]}}, cx1};
  assign sum_y = {{(SUM_BITS-COORD_BITS){pos_y[COORD_BITS-1]}}, pos_y}
               + {{(SUM_BITS-32){cy1[31]}}, cy1};
  assign org_x = {{(SUM_BITS-32){cx1[31]}}, cx1};
  assign org_y = {{(SUM_BITS-32){cy1[31]}}, cy1};

  always_comb begin
    pos_x_next      = pos_x;
    pos_y_next      = pos_y;
    pixel_mode_next = pixel_mode;
    case (mode1)
      MODE_START_SUB: begin
        pos_x_next      = sat_pos(org_x);
        pos_y_next      = sat_pos(org_y);
        pixel_mode_next = 1'b0;
      end
      MODE_START_PIX: begin
        pos_x_next      = sat_pos(org_x);
        pos_y_next      = sat_pos(org_y);
        pixel_mode_next = 1'b1;
      end
      MODE_DAB: begin
        pos_x_next = sat_pos(sum_x);
        pos_y_next = sat_pos(sum_y);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      pos_y      <= '0;
      pixel_mode <= 1'b0;
      v2         <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
      if (v1) begin
        pos_x      <= pos_x_next;
        pos_y      <= pos_y_next;
        pixel_mode <= pixel_mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v1) begin
      mode2 <= mode1;
      pix2  <= pixel_mode_next;
      px2   <= pos_x_next;
      py2   <= pos_y_next;
      size2 <= size1;
      last2 <= last1;
    end
  end

  assign ctl.pixel = pix2;
  assign ctl.seed  = (mode2 == MODE_START_SUB) || (mode2 == MODE_START_PIX);

  dbb_axis_span u_span_x (
    .pos   (px2),
    .dsize (size2),
    .ctl   (ctl),
    .lo    (lo_x),
    .hi    (hi_x)
  );

  dbb_axis_span u_span_y (
    .pos   (py2),
    .dsize (size2),
    .ctl   (ctl),
    .lo    (lo_y),
    .hi    (hi_y)
  );

  always_comb begin
    min_x_next = min_x;
    min_y_next = min_y;
    max_x_next = max_x;
    max_y_next = max_y;
    case (mode2)
      MODE_START_SUB, MODE_START_PIX: begin
        min_x_next = lo_x;
        max_x_next = hi_x;
        min_y_next = lo_y;
        max_y_next = hi_y;
      end
      MODE_DAB: begin
        if (lo_x < min_x) min_x_next = lo_x;
        if (lo_y < min_y) min_y_next = lo_y;
        if (hi_x > max_x) max_x_next = hi_x;
        if (hi_y > max_y) max_y_next = hi_y;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= '0;
      min_y <= '0;
      max_x <= '0;
      max_y <= '0;
    end else if (advance && v2) begin
      min_x <= min_x_next;
      min_y <= min_y_next;
      max_x <= max_x_next;
      max_y <= max_y_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && v2 && last2) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v2 && last2) begin
      m_tdata <= {max_y_next, max_x_next, min_y_next, min_x_next};
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for dab_stroke_bounding_box_unit, with directed
// strokes then random ones; boxes checked against a local model or a fixed box.
// Depends on dbb_pkg and the unit's rtl.
module tb_top;
  import dbb_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int N_REQS = 650;
  localparam int HANG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [15:0]        size;
    logic               last;
  } stroke_req_t;

  // first member sits in the top bits, so left lands in m_tdata[31:0]
  typedef struct packed {
    logic signed [31:0] bottom;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic signed [31:0] left;
  } box_t;

  typedef struct {
    stroke_req_t req;
    bit          typed;
    box_t        box;
  } dir_row_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;   // coord_x, coord_y, dsize
  logic [1:0]   s_tuser = '0;   // mode
  logic         s_tlast = 1'b0; // last
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // box_left, box_top, box_right, box_bottom

  // running stroke state of the local model
  longint cur_x = 0, cur_y = 0;
  longint lo_x = 0, lo_y = 0, hi_x = 0, hi_y = 0;
  bit     pix_mode = 1'b0;

  box_t     expected_boxes[$];
  dir_row_t dir_rows[$];
  bit       row_typed = 1'b0;
  box_t     row_box = '0;
  bit       calm = 1'b0;
  int       req_count = 0;
  int       errors = 0;
  int       hang_cycles = 0;
  string    field_name[4] = '{"box_left", "box_top", "box_right", "box_bottom"};

  dab_stroke_bounding_box_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip_coord(input longint v);
    longint hi;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
  endfunction

  function automatic longint clip_box(input longint v);
    return (v > 64'sh7fff_ffff) ? 64'sh7fff_ffff :
           ((v < -64'sh8000_0000) ? -64'sh8000_0000 : v);
  endfunction

  function automatic void seed_box(input longint x, input longint y);
    lo_x = clip_box(x);
    hi_x = lo_x;
    lo_y = clip_box(y);
    hi_y = lo_y;
  endfunction

  function automatic void grow_box(input longint l, input longint t,
                                   input longint r, input longint b);
    l = clip_box(l);
    t = clip_box(t);
    r = clip_box(r);
    b = clip_box(b);
    if (l < lo_x) lo_x = l;
    if (t < lo_y) lo_y = t;
    if (r > hi_x) hi_x = r;
    if (b > hi_y) hi_y = b;
  endfunction

  // advances the stroke state by one request; returns 1 when a box leaves
  function automatic bit stroke_box(input stroke_req_t r, output box_t b);
    longint sz, d, h, l, t, span;
    sz = longint'(r.size);
    case (r.mode)
      MODE_START_SUB: begin
        pix_mode = 1'b0;
        cur_x = clip_coord(r.cx);
        cur_y = clip_coord(r.cy);
        seed_box(cur_x / 4, cur_y / 4);
      end
      MODE_START_PIX: begin
        pix_mode = 1'b1;
        cur_x = clip_coord(r.cx);
        cur_y = clip_coord(r.cy);
        seed_box(cur_x, cur_y);
      end
      MODE_DAB: begin
        cur_x = clip_coord(cur_x + longint'(r.cx));
        cur_y = clip_coord(cur_y + longint'(r.cy));
        if (pix_mode) begin
          d = sz + 1;
          h = d / 2;
          l = cur_x - h;
          t = cur_y - h;
          grow_box(l, t, l + d - 1, t + d - 1);
        end else begin
          // 1/512 pixel units, division truncates toward zero
          span = sz / 256;
          l = (cur_x * 128 - sz) / 512;
          t = (cur_y * 128 - sz) / 512;
          grow_box(l, t, l + span, t + span);
        end
      end
      default: ;
    endcase
    b.left   = lo_x[31:0];
    b.top    = lo_y[31:0];
    b.right  = hi_x[31:0];
    b.bottom = hi_y[31:0];
    return r.last;
  endfunction

  function automatic box_t mk_box(input logic [31:0] l, input logic [31:0] t,
                                  input logic [31:0] r, input logic [31:0] b);
    box_t v;
    v.left = l;
    v.top = t;
    v.right = r;
    v.bottom = b;
    return v;
  endfunction

  task automatic add_row(input logic [1:0] mode, input logic [31:0] cx,
                         input logic [31:0] cy, input logic [15:0] size,
                         input logic last, input bit typed, input box_t box);
    dir_row_t row;
    row.req.mode = mode;
    row.req.cx = cx;
    row.req.cy = cy;
    row.req.size = size;
    row.req.last = last;
    row.typed = typed;
    row.box = box;
    dir_rows.push_back(row);
  endtask

  // mostly a small signed spread, now and then the full 32-bit range
  function automatic logic [31:0] pick_offset(input int spread);
    int v;
    if ($urandom_range(99) < 10) return $urandom;
    v = int'($urandom_range(0, 2 * spread)) - spread;
    return v;
  endfunction

  task automatic send_req(input stroke_req_t r, input bit typed, input box_t want);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(99) < 7) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.size, r.cy, r.cx};
    s_tuser  <= r.mode;
    s_tlast  <= r.last;
    row_typed = typed;
    row_box = want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    req_count++;
  endtask

  task automatic random_stroke();
    stroke_req_t r;
    stroke_req_t spare;
    int dabs;
    bit pix;
    if ($urandom_range(99) < 10) begin
      // noise: any mode, any fields
      r.mode = 2'($urandom_range(0, 3));
      r.cx = $urandom;
      r.cy = $urandom;
      r.size = 16'($urandom);
      r.last = 1'($urandom_range(0, 1));
      send_req(r, 1'b0, '0);
      return;
    end
    pix = 1'($urandom_range(0, 1));
    r.mode = pix ? MODE_START_PIX : MODE_START_SUB;
    r.cx = pick_offset(pix ? 5000 : 20000);
    r.cy = pick_offset(pix ? 5000 : 20000);
    r.size = 16'($urandom);
    r.last = ($urandom_range(99) < 3);
    send_req(r, 1'b0, '0);
    dabs = $urandom_range(1, 12);
    for (int k = 1; k <= dabs; k++) begin
      if ($urandom_range(99) < 5) begin
        spare.mode = MODE_SPARE;
        spare.cx = $urandom;
        spare.cy = $urandom;
        spare.size = 16'($urandom);
        spare.last = 1'($urandom_range(0, 1));
        send_req(spare, 1'b0, '0);
      end
      r.mode = MODE_DAB;
      r.cx = pick_offset(pix ? 40 : 600);
      r.cy = pick_offset(pix ? 40 : 600);
      if (pix && $urandom_range(99) >= 10) r.size = 16'($urandom_range(0, 64));
      else r.size = 16'($urandom);
      r.last = (k == dabs) || ($urandom_range(99) < 4);
      send_req(r, 1'b0, '0);
    end
  endtask

  // receiver stalls at random outside the calm stretch
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    stroke_req_t r;
    box_t calc;
    box_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        r.mode = s_tuser;
        r.cx = s_tdata[31:0];
        r.cy = s_tdata[63:32];
        r.size = s_tdata[79:64];
        r.last = s_tlast;
        if (stroke_box(r, calc)) expected_boxes.push_back(row_typed ? row_box : calc);
      end
      if (m_tvalid && m_tready) begin
        if (expected_boxes.size() == 0) begin
          $display("%0t unexpected box: expected none, got %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_boxes.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (m_tdata[32*k +: 32] !== want[32*k +: 32]) begin
              $display("%0t %s mismatch: expected %0d, got %0d", $time, field_name[k],
                       $signed(want[32*k +: 32]), $signed(m_tdata[32*k +: 32]));
              errors++;
            end
          end
        end
      end
    end
  end

  // watchdog on cycles in which neither side moves a request or a box
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) hang_cycles <= 0;
    else hang_cycles <= hang_cycles + 1;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // reset state, extremes and the odd cases first
    add_row(MODE_SPARE, 32'd0, 32'd0, 16'd0, 1'b1, 1'b1, mk_box(0, 0, 0, 0));
    add_row(MODE_DAB, 32'd5, -32'sd7, 16'hffff, 1'b1, 1'b0, '0);
    add_row(MODE_START_SUB, 32'h7fff_ffff, 32'h8000_0000, 16'd0, 1'b1, 1'b1,
            mk_box(32'h1fff_ffff, 32'he000_0000, 32'h1fff_ffff, 32'he000_0000));
    add_row(MODE_DAB, 32'h7fff_ffff, 32'h8000_0000, 16'hffff, 1'b1, 1'b0, '0);
    add_row(MODE_START_PIX, 32'h8000_0000, 32'h7fff_ffff, 16'd0, 1'b1, 1'b1,
            mk_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    add_row(MODE_DAB, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1'b0, 1'b0, '0);
    add_row(MODE_DAB, 32'd0, 32'd0, 16'hffff, 1'b1, 1'b0, '0);
    add_row(MODE_START_PIX, 32'd0, 32'd0, 16'd0, 1'b0, 1'b0, '0);
    add_row(MODE_DAB, 32'd0, 32'd0, 16'd0, 1'b1, 1'b1, mk_box(0, 0, 0, 0));
    add_row(MODE_DAB, 32'd10, -32'sd10, 16'd1, 1'b0, 1'b0, '0);
    add_row(MODE_DAB, -32'sd3, 32'd3, 16'd2, 1'b0, 1'b0, '0);
    add_row(MODE_SPARE, 32'd123, 32'd456, 16'd789, 1'b0, 1'b0, '0);
    add_row(MODE_DAB, 32'd0, 32'd0, 16'hffff, 1'b1, 1'b0, '0);
    add_row(MODE_START_SUB, -32'sd5, -32'sd3, 16'd0, 1'b0, 1'b0, '0);
    add_row(MODE_DAB, -32'sd1, 32'd1, 16'd255, 1'b0, 1'b0, '0);
    add_row(MODE_DAB, 32'd0, 32'd0, 16'd256, 1'b0, 1'b0, '0);
    add_row(MODE_DAB, -32'sd100, 32'd37, 16'd511, 1'b1, 1'b0, '0);
    add_row(MODE_SPARE, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1'b1, 1'b0, '0);
    add_row(MODE_START_SUB, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 1'b0, 1'b0, '0);
    add_row(MODE_DAB, 32'd0, 32'd0, 16'hffff, 1'b1, 1'b0, '0);
    add_row(MODE_START_SUB, 32'h8000_0000, 32'h8000_0000, 16'd0, 1'b0, 1'b0, '0);
    add_row(MODE_DAB, 32'd0, 32'd0, 16'hffff, 1'b1, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].box);

    while (req_count < N_REQS) begin
      calm = (req_count >= 300) && (req_count < 420);
      random_stroke();
    end
    calm = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
